// ===== rtl/core/murmur3_byte_stream_hash_top_assert.svh =====
// Assertion macros shared by the murmur3 byte stream hash RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef MURMUR3_BYTE_STREAM_HASH_TOP_ASSERT_SVH
`define MURMUR3_BYTE_STREAM_HASH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define M3BH_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("m3bh invariant violated");
`define M3BH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("m3bh sequence violated");
`else
`define M3BH_ASSERT(label, expr)
`define M3BH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/m3bh_pkg.sv =====
// Types, constants and helper functions for the murmur3 byte stream hash.
// Used by the front, queue, back and top level modules; depends on nothing.
package m3bh_pkg;

    localparam logic [31:0] C1      = 32'hcc9e2d51;
    localparam logic [31:0] C2      = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] F1      = 32'h85ebca6b;
    localparam logic [31:0] F2      = 32'hc2b2ae35;

    typedef enum logic [1:0] {
        OP_BLOCK,
        OP_BLOCK_FINAL,
        OP_TAIL_FINAL
    } op_kind_t;

    typedef struct packed {
        op_kind_t    kind;
        logic        first;
        logic [31:0] word;
        logic [31:0] length;
    } op_t;

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        return {v[18:0], v[31:19]};
    endfunction

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        return {v[16:0], v[31:17]};
    endfunction

endpackage

// ===== rtl/core/m3bh_front.sv =====
// Front end: accepts message bytes, packs them into little-endian blocks and
// counts the length, then queues block and finish operations. Uses m3bh_pkg.
module m3bh_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // [7:0] data_byte
    input  logic           s_tlast,
    input  logic           q_full,
    output logic           q_push,
    output m3bh_pkg::op_t  q_op
);

    logic [23:0] part_reg;
    logic [23:0] part_next;
    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic [31:0] len_reg;
    logic [31:0] len_next;
    logic        first_pending_reg;
    logic        first_pending_next;
    logic        accept;
    logic [31:0] len_inc;
    logic [23:0] part_ins;
    logic        finish_push;
    logic        msg_cleared;

    assign s_tready    = !q_full;
    assign accept      = s_tvalid && s_tready;
    assign len_inc     = len_reg + 32'd1;
    assign finish_push = q_push && (q_op.kind != m3bh_pkg::OP_BLOCK);
    assign msg_cleared = (len_reg == '0) && (pos_reg == 2'd0) && first_pending_reg;

    always_comb
    begin
        part_ins = part_reg;
        unique case (pos_reg)
            2'd0:    part_ins[7:0]   = s_tdata;
            2'd1:    part_ins[15:8]  = s_tdata;
            2'd2:    part_ins[23:16] = s_tdata;
            default: part_ins        = part_reg;
        endcase
    end

    always_comb
    begin
        q_push             = 1'b0;
        q_op.kind          = m3bh_pkg::OP_BLOCK;
        q_op.first         = first_pending_reg;
        q_op.word          = {8'd0, part_ins};
        q_op.length        = len_inc;
        part_next          = part_reg;
        pos_next           = pos_reg;
        len_next           = len_reg;
        first_pending_next = first_pending_reg;
        if (accept)
        begin
            if (pos_reg == 2'd3)
            begin
                q_push    = 1'b1;
                q_op.word = {s_tdata, part_reg};
                q_op.kind = s_tlast ? m3bh_pkg::OP_BLOCK_FINAL : m3bh_pkg::OP_BLOCK;
                part_next = '0;
                pos_next  = 2'd0;
            end
            else
            begin
                part_next = part_ins;
                pos_next  = pos_reg + 2'd1;
                if (s_tlast)
                begin
                    q_push    = 1'b1;
                    q_op.kind = m3bh_pkg::OP_TAIL_FINAL;
                end
            end
            len_next = len_inc;
            if (q_push)
            begin
                first_pending_next = 1'b0;
            end
            if (s_tlast)
            begin
                part_next          = '0;
                pos_next           = 2'd0;
                len_next           = '0;
                first_pending_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg          <= '0;
            pos_reg           <= '0;
            len_reg           <= '0;
            first_pending_reg <= 1'b1;
        end
        else
        begin
            part_reg          <= part_next;
            pos_reg           <= pos_next;
            len_reg           <= len_next;
            first_pending_reg <= first_pending_next;
        end
    end

`include "murmur3_byte_stream_hash_top_assert.svh"

    `M3BH_ASSERT(a_part_empty_at_block_start, (pos_reg != 2'd0) || (part_reg == '0))
    `M3BH_ASSERT_NEXT(a_finish_clears_message, finish_push, msg_cleared)

endmodule

// ===== rtl/core/m3bh_queue.sv =====
// Short operation queue between the front and back ends of the hash.
// Register storage with one write and one read pointer; uses m3bh_pkg.
module m3bh_queue #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  m3bh_pkg::op_t  push_op,
    output logic           full,
    input  logic           pop,
    output m3bh_pkg::op_t  head_op,
    output logic           empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    m3bh_pkg::op_t   mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [AW:0]     count_reg;
    logic [AW:0]     count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head_op = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`include "murmur3_byte_stream_hash_top_assert.svh"

    `M3BH_ASSERT(a_count_in_range, count_reg <= (AW+1)'(DEPTH))
    `M3BH_ASSERT_NEXT(a_push_only_grows, do_push && !do_pop, count_reg == $past(count_next))

endmodule

// ===== rtl/core/m3bh_back.sv =====
// Back end: mixes queued blocks into the running hash, finishes messages
// and holds the result in an output register. Uses m3bh_pkg.
module m3bh_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [31:0]    seed,
    input  logic           q_empty,
    output logic           q_pop,
    input  m3bh_pkg::op_t  q_op,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata    // [31:0] hash
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_K1,
        S_K2,
        S_MIX,
        S_F1,
        S_F2,
        S_OUT
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [31:0]     out_hash_reg;
    logic [31:0]     out_hash_next;
    m3bh_pkg::op_t   op_reg;
    m3bh_pkg::op_t   op_next;
    logic [31:0]     k_reg;
    logic [31:0]     k_next;
    logic [31:0]     h_reg;
    logic [31:0]     h_next;
    logic [31:0]     t_reg;
    logic [31:0]     t_next;
    logic [31:0]     h_in;
    logic [31:0]     h_rot;
    logic [31:0]     h_mix;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_hash_reg;
    assign h_in     = op_reg.first ? seed : h_reg;
    assign h_rot    = m3bh_pkg::rotl13(h_in ^ k_reg);
    assign h_mix    = {h_rot[29:0], 2'b00} + h_rot + m3bh_pkg::MIX_ADD;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;
        op_next        = op_reg;
        k_next         = k_reg;
        h_next         = h_reg;
        t_next         = t_reg;
        q_pop          = 1'b0;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    op_next    = q_op;
                    state_next = S_K1;
                end
            end
            S_K1:
            begin
                k_next     = op_reg.word * m3bh_pkg::C1;
                state_next = S_K2;
            end
            S_K2:
            begin
                k_next     = m3bh_pkg::rotl15(k_reg) * m3bh_pkg::C2;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                unique case (op_reg.kind)
                    m3bh_pkg::OP_BLOCK:
                    begin
                        h_next     = h_mix;
                        state_next = S_IDLE;
                    end
                    m3bh_pkg::OP_BLOCK_FINAL:
                    begin
                        h_next     = h_mix;
                        t_next     = h_mix ^ op_reg.length;
                        state_next = S_F1;
                    end
                    default:
                    begin
                        t_next     = h_in ^ k_reg ^ op_reg.length;
                        state_next = S_F1;
                    end
                endcase
            end
            S_F1:
            begin
                t_next     = (t_reg ^ {16'd0, t_reg[31:16]}) * m3bh_pkg::F1;
                state_next = S_F2;
            end
            S_F2:
            begin
                t_next     = (t_reg ^ {13'd0, t_reg[31:13]}) * m3bh_pkg::F2;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_hash_next  = t_reg ^ {16'd0, t_reg[31:16]};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_hash_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_hash_reg  <= out_hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        k_reg  <= k_next;
        h_reg  <= h_next;
        t_reg  <= t_next;
    end

endmodule

// ===== rtl/core/murmur3_byte_stream_hash_top.sv =====
// Top level of the MurmurHash3 x86 32-bit byte stream hash.
// Holds the seed register and connects m3bh_front, m3bh_queue and m3bh_back.
//
// Usage: message bytes arrive one per transfer on the s_ channel, with
// s_tlast set on the final byte of each message; every message has at least
// one byte. One 32-bit hash leaves on the m_ channel per message. The seed is
// written on the cfg_ channel (always ready) while no message is in flight
// and applies to every following message.
// The front end takes one byte per cycle while the queue has room. It queues
// one operation per completed four-byte block, the one that ends a message
// also finishing it, and one per message ending in a partial block. The back
// end runs a block through K1, K2 and MIX and a message end on through F1, F2
// and OUT, mostly a serial chain of 32-bit multiplies, so long messages run at
// about one byte per cycle unless the output stalls. When m_tready stays low,
// the finished hash waits in the output register, the back end stops at its
// next result, the queue fills and s_tready falls. Reset clears the seed to
// zero and drops any partial message, queued work and pending result.
module murmur3_byte_stream_hash_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] hash
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data   // [31:0] seed
);

    logic [31:0]    seed_reg;
    logic [31:0]    seed_next;
    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    m3bh_pkg::op_t  push_op;
    m3bh_pkg::op_t  head_op;

    assign cfg_ready = 1'b1;
    assign seed_next = (cfg_valid && cfg_ready) ? cfg_data : seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    m3bh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (push_op)
    );

    m3bh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (q_pop),
        .head_op (head_op),
        .empty   (q_empty)
    );

    m3bh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .seed     (seed_reg),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_op     (head_op),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for murmur3_byte_stream_hash_top: random and directed byte messages
// are hashed by an in-bench MurmurHash3 x86_32 predictor and compared per output transfer.
// Depends on m3bh_pkg for the mixing constants and on the top level RTL.
module tb_top;

    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 225;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE_STALL,
        RX_PATTERN
    } rx_mode_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    logic [31:0] model_seed = '0;
    logic [31:0] acc_hash   = '0;
    logic [23:0] tail_bytes = '0;
    logic [1:0]  tail_count = '0;
    logic [31:0] msg_len    = '0;
    logic        msg_open   = 1'b0;
    logic [31:0] pending_hashes[$];
    int          error_count = 0;

    int          burst_left  = 0;
    int          tx_gap_max  = 0;
    int          tx_burst_max = 8;
    rx_mode_t    rx_mode     = RX_ALWAYS;
    int          hold_seq    = 0;
    int          hold_seen   = 0;
    int          hold_left   = 0;
    int          rx_tick     = 0;

    murmur3_byte_stream_hash_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] mix_word(input logic [31:0] k);
        logic [31:0] v;
        v = k * m3bh_pkg::C1;
        v = {v[16:0], v[31:17]};
        return v * m3bh_pkg::C2;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] v;
        v = h ^ (h >> 16);
        v = v * m3bh_pkg::F1;
        v = v ^ (v >> 13);
        v = v * m3bh_pkg::F2;
        return v ^ (v >> 16);
    endfunction

    task automatic absorb_byte(input logic [7:0] b, input logic is_last);
        logic [31:0] h;
        if (!msg_open)
        begin
            acc_hash   = model_seed;
            tail_bytes = '0;
            tail_count = '0;
            msg_len    = '0;
            msg_open   = 1'b1;
        end
        if (tail_count == 2'd3)
        begin
            h = acc_hash ^ mix_word({b, tail_bytes});
            h = {h[18:0], h[31:19]};
            acc_hash   = h * 32'd5 + m3bh_pkg::MIX_ADD;
            tail_bytes = '0;
            tail_count = '0;
        end
        else
        begin
            tail_bytes = tail_bytes | ({16'd0, b} << (8 * tail_count));
            tail_count = tail_count + 2'd1;
        end
        msg_len = msg_len + 32'd1;
        if (is_last)
        begin
            h = acc_hash;
            if (tail_count != 2'd0)
                h = h ^ mix_word({8'd0, tail_bytes});
            h = h ^ msg_len;
            pending_hashes = {pending_hashes, avalanche(h)};
            msg_open = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        logic [31:0] expected;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                model_seed = cfg_data;
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (pending_hashes.size() == 0)
                begin
                    $display("%0t: unexpected hash transfer, expected none, actual %08h",
                             $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    expected = pending_hashes.pop_front();
                    if (m_tdata !== expected)
                    begin
                        $display("%0t: hash mismatch, expected %08h, actual %08h",
                                 $time, expected, m_tdata);
                        error_count++;
                    end
                end
            end
        end
    end

    // The receiver follows its own stall pattern, and a hold request forces a long stall.
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        rx_tick++;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:       m_tready <= 1'b1;
                RX_RANDOM:       m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE_STALL: m_tready <= ($urandom_range(0, 7) != 0);
                default:         m_tready <= (rx_tick[1:0] != 2'b11);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, tx_gap_max);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, tx_burst_max);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_hashes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // With the reset seed, messages of one to five bytes cover every tail length and a full block.
    task automatic test_reset_seed_lengths();
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hff, 1'b1);
        for (int i = 0; i < 4; i++)
            send_byte(8'hff, i == 3);
        for (int i = 0; i < 5; i++)
            send_byte(8'h00, i == 4);
    endtask

    task automatic test_seed_extremes();
        write_seed(32'hffff_ffff);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'haa, 1'b1);
        write_seed(32'h0000_0000);
        send_byte(8'h7f, 1'b0);
        send_byte(8'hfe, 1'b1);
        write_seed(32'h8000_0001);
        for (int i = 0; i < 8; i++)
            send_byte(8'hff, i == 7);
    endtask

    task automatic test_random_messages();
        int sent;
        int len;
        int pick;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1:       write_seed(32'hffff_ffff);
                3:       write_seed(32'h0000_0000);
                default: write_seed($urandom);
            endcase
            rx_mode <= rx_mode_t'(phase % 4);
            if (phase % 3 == 0)
            begin
                tx_gap_max   = 0;
                tx_burst_max = 64;
            end
            else
            begin
                tx_gap_max   = phase + 1;
                tx_burst_max = 8;
            end
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    len = $urandom_range(1, 12);
                else if (pick < 95)
                    len = $urandom_range(13, 64);
                else
                    len = $urandom_range(65, 200);
                send_message(len);
                sent += len;
            end
        end
    endtask

    // The receiver stalls for a long stretch while short messages keep coming, so the
    // result path backs up and the input must stall.
    task automatic test_output_backpressure();
        write_seed($urandom);
        tx_gap_max   = 0;
        tx_burst_max = 64;
        rx_mode  <= RX_RANDOM;
        hold_seq <= hold_seq + 1;
        for (int i = 0; i < 30; i++)
            send_message($urandom_range(1, 4));
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_reset_seed_lengths();
        test_seed_extremes();
        test_random_messages();
        test_output_backpressure();
        wait_idle();
        if (error_count == 0 && pending_hashes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
